// ----- hdl/mdcfe_pkg.sv -----
package mdcfe_pkg;

    localparam int unsigned HEAD_WORDS = 6;
    localparam int unsigned CODED_WORDS = 7;
    localparam int unsigned CODED_BYTES = 14;
    localparam int unsigned PAYLOAD_BYTES = 4;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    localparam logic [3:0] WORD_LAST = 4'd12;
    localparam logic [3:0] WORD_FIRST_CODED = 4'd6;

    // preamble 0x55 x7 then sync 07 09 2a 44 6f
    localparam logic [15:0] HEAD_WORD [HEAD_WORDS] = '{
        16'h5555, 16'h5555, 16'h5555, 16'h5507, 16'h092A, 16'h446F
    };

    typedef logic [CODED_BYTES-1:0][7:0] t_block;
    typedef logic [CODED_WORDS-1:0][15:0] t_words;
    typedef logic [PAYLOAD_BYTES-1:0][7:0] t_payload;

    typedef struct packed {
        logic [6:0] sr;
        logic [7:0] par;
    } t_conv;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        logic fb;
        c = crc_in;
        for (int b = 0; b < 8; b++) begin
            fb = c[15] ^ d[b];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_final(input logic [15:0] crc_in);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = crc_in[15-i];
        end
        return r ^ CRC_XOROUT;
    endfunction

    function automatic t_conv conv_byte(input logic [6:0] sr_in, input logic [7:0] d);
        t_conv res;
        logic [6:0] sr;
        sr = sr_in;
        res.par = '0;
        for (int j = 0; j < 8; j++) begin
            sr = {sr[5:0], d[j]};
            res.par[j] = sr[0] ^ sr[2] ^ sr[5] ^ sr[6];
        end
        res.sr = sr;
        return res;
    endfunction

    // 7 by 16 interleave, msb first within each word
    function automatic t_words interleave(input t_block blk);
        t_words w;
        w = '0;
        for (int s = 0; s < CODED_BYTES * 8; s++) begin
            w[s % 7][15 - (s / 7)] = blk[s / 8][s % 8];
        end
        return w;
    endfunction

endpackage

// ----- hdl/mdcfe_front.sv -----
module mdcfe_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [7:0]            i_op,
    input  logic [7:0]            i_arg,
    input  logic [15:0]           i_unit_id,
    output logic                  o_q_push,
    output mdcfe_pkg::t_words     o_q_data,
    input  logic                  i_q_ready
);
    import mdcfe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_CONV,
        S_PUSH
    } t_state;

    t_state      r_state;
    logic [2:0]  r_cnt;
    t_payload    r_pl;
    logic [15:0] r_crc;
    logic [6:0]  r_sr;
    logic [6:0][7:0] r_par;

    logic [15:0] crc_out;
    logic [7:0]  conv_in;
    t_conv       conv_res;
    t_block      blk;

    assign crc_out = crc_final(r_crc);

    always_comb begin
        case (r_cnt)
            3'd0, 3'd1, 3'd2, 3'd3: conv_in = r_pl[r_cnt[1:0]];
            3'd4:    conv_in = crc_out[7:0];
            3'd5:    conv_in = crc_out[15:8];
            default: conv_in = 8'h00;
        endcase
    end

    assign conv_res = conv_byte(r_sr, conv_in);

    always_comb begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            blk[i] = r_pl[i];
        end
        blk[4] = crc_out[7:0];
        blk[5] = crc_out[15:8];
        blk[6] = 8'h00;
        for (int i = 0; i < 7; i++) begin
            blk[7 + i] = r_par[i];
        end
    end

    assign o_q_data = interleave(blk);
    assign o_q_push = (r_state == S_PUSH) && i_q_ready;
    assign o_full   = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_pl[0] <= i_op;
                        r_pl[1] <= i_arg;
                        r_pl[2] <= i_unit_id[15:8];
                        r_pl[3] <= i_unit_id[7:0];
                        r_crc   <= '0;
                        r_sr    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_CRC;
                    end
                end
                S_CRC: begin
                    r_crc <= crc_byte(r_crc, r_pl[r_cnt[1:0]]);
                    if (r_cnt == 3'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_CONV;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_CONV: begin
                    r_sr         <= conv_res.sr;
                    r_par[r_cnt] <= conv_res.par;
                    if (r_cnt == 3'd6) begin
                        r_cnt   <= '0;
                        r_state <= S_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_PUSH: begin
                    if (i_q_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/mdcfe_queue.sv -----
module mdcfe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mdcfe_pkg::t_words i_data,
    output logic              o_ready,
    output logic              o_valid,
    output mdcfe_pkg::t_words o_data,
    input  logic              i_pop
);
    import mdcfe_pkg::*;

    t_words     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready) else $error("queue write while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue read while empty");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step with count");
`endif

endmodule

// ----- hdl/mdcfe_back.sv -----
module mdcfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  mdcfe_pkg::t_words i_q_data,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [15:0]       o_fifo_word,
    output logic [3:0]        o_word_index,
    output logic              o_last_word
);
    import mdcfe_pkg::*;

    logic [3:0]  r_cnt;
    logic        r_valid;
    logic [15:0] r_word;
    logic [3:0]  r_idx;
    logic        r_last;

    logic        load;
    logic [3:0]  coded_idx;
    logic [15:0] next_word;

    assign load      = i_q_valid && (!r_valid || i_pop);
    assign coded_idx = r_cnt - WORD_FIRST_CODED;
    assign o_q_pop   = load && (r_cnt == WORD_LAST);

    always_comb begin
        if (r_cnt < WORD_FIRST_CODED) begin
            next_word = HEAD_WORD[r_cnt[2:0]];
        end else begin
            next_word = i_q_data[coded_idx[2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_word  <= next_word;
                r_idx   <= r_cnt;
                r_last  <= (r_cnt == WORD_LAST);
                r_cnt   <= (r_cnt == WORD_LAST) ? 4'd0 : r_cnt + 4'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_valid;
    assign o_fifo_word  = r_word;
    assign o_word_index = r_idx;
    assign o_last_word  = r_last;

`ifndef NO_ASSERTIONS
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_cnt == 4'd0))
        else $error("word counter did not wrap after last word");
    a_cnt_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_cnt == r_idx + 4'd1))
        else $error("word counter out of step with shown word");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_last == (r_idx == WORD_LAST)))
        else $error("last flag does not match word index");
    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_valid && r_last))
        else $error("frame released before its last word");
`endif

endmodule

// ----- hdl/mdc1200_frame_encoder.sv -----
// MDC-1200 frame encoder: each request (opcode, argument, unit ID) becomes one 26-byte
// frame (preamble, sync, CRC-protected, convolutionally coded and interleaved block),
// delivered as 13 big-endian 16-bit words with index 0..12 and a last-word flag. A request
// occupies the front end after acceptance for 4 CRC byte steps, 7 coding byte steps and one
// write into a 2-frame queue, which waits while the queue is full; no new request is taken
// until that write is done. The back end emits one word per cycle while a frame is queued
// and the output is popped, and the 2-frame queue lets the next request enter while earlier
// words are still waiting to be popped.
module mdc1200_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_op,
    input  logic [7:0]  i_arg,
    input  logic [15:0] i_unit_id,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_fifo_word,
    output logic [3:0]  o_word_index,
    output logic        o_last_word
);
    import mdcfe_pkg::*;

    logic   q_push;
    logic   q_ready;
    logic   q_valid;
    logic   q_pop;
    t_words q_wdata;
    t_words q_rdata;

    mdcfe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_op      (i_op),
        .i_arg     (i_arg),
        .i_unit_id (i_unit_id),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata),
        .i_q_ready (q_ready)
    );

    mdcfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    mdcfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_fifo_word  (o_fifo_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

endmodule
